>>> hw/rtl/atm_pkg.sv
`timescale 1ns / 1ps

package atm_pkg;

  // field and datapath widths
  localparam int unsigned AxisW   = 16;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned SqW     = 31;  // one squared axis, unsigned
  localparam int unsigned SumW    = 32;  // sum of two squares
  localparam int unsigned RadW    = 48;  // sum of squares times 65536
  localparam int unsigned RootW   = 24;
  localparam int unsigned RemW    = 27;
  localparam int unsigned CordW   = 28;
  localparam int unsigned ZW      = 25;
  localparam int unsigned Steps   = 18;
  localparam int unsigned StepW   = 5;
  localparam int signed   AngleLimit = 23040;

  typedef logic signed [AxisW-1:0]  axis_t;
  typedef logic signed [AngleW-1:0] angle_t;

  // atan(2^-i) in degrees times 65536
  function automatic logic signed [ZW-1:0] atan_q16(input logic [StepW-1:0] i);
    logic signed [ZW-1:0] t;
    begin
      unique case (i)
        5'd0:  t = 25'sd2949120;
        5'd1:  t = 25'sd1740967;
        5'd2:  t = 25'sd919879;
        5'd3:  t = 25'sd466945;
        5'd4:  t = 25'sd234379;
        5'd5:  t = 25'sd117304;
        5'd6:  t = 25'sd58666;
        5'd7:  t = 25'sd29335;
        5'd8:  t = 25'sd14668;
        5'd9:  t = 25'sd7334;
        5'd10: t = 25'sd3667;
        5'd11: t = 25'sd1833;
        5'd12: t = 25'sd917;
        5'd13: t = 25'sd458;
        5'd14: t = 25'sd229;
        5'd15: t = 25'sd115;
        5'd16: t = 25'sd57;
        5'd17: t = 25'sd29;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage

>>> hw/rtl/atm_if.sv
`timescale 1ns / 1ps

// sample channel
interface atm_in_if;
  logic          valid;
  logic          ready;
  atm_pkg::axis_t accel_x;
  atm_pkg::axis_t accel_y;
  atm_pkg::axis_t accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

// result channel
interface atm_out_if;
  logic            valid;
  logic            ready;
  atm_pkg::angle_t instant_pitch;
  atm_pkg::angle_t instant_roll;
  atm_pkg::angle_t mean_pitch;
  atm_pkg::angle_t mean_roll;

  modport source (output valid, output instant_pitch, output instant_roll,
                  output mean_pitch, output mean_roll, input ready);
  modport sink   (input valid, input instant_pitch, input instant_roll,
                  input mean_pitch, input mean_roll, output ready);
endinterface

>>> hw/rtl/atm_isqrt.sv
`timescale 1ns / 1ps

// floor(sqrt(sum * 65536)), two radicand bits per cycle
module atm_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [atm_pkg::SumW-1:0]    sum_i,
  output logic                        done_o,
  output logic [atm_pkg::RootW-1:0]   root_o
);

  logic [atm_pkg::RadW-1:0]  rad_q, rad_d;
  logic [atm_pkg::RemW-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [atm_pkg::RootW-1:0] root_q, root_d;
  logic [atm_pkg::StepW-1:0] cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;

  // one root digit
  always_comb begin
    rem_sh = {rem_q[atm_pkg::RemW-3:0], rad_q[atm_pkg::RadW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = {sum_i, 16'h0000};
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[atm_pkg::RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[atm_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[atm_pkg::RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == atm_pkg::StepW'(atm_pkg::RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> hw/rtl/atm_cordic.sv
`timescale 1ns / 1ps

// vectoring cordic, one micro-rotation per cycle
module atm_cordic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [atm_pkg::RootW-1:0]    den_i,
  input  logic signed [atm_pkg::AxisW:0] num_i,
  output logic                         done_o,
  output atm_pkg::angle_t              angle_o
);

  localparam int unsigned RW = atm_pkg::ZW - 8;

  logic signed [atm_pkg::CordW-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [atm_pkg::ZW-1:0]    z_q, z_d, zr;
  logic signed [RW-1:0]             r;
  logic [atm_pkg::StepW-1:0]        cnt_q, cnt_d;
  logic                             busy_q, busy_d, done_q, done_d, zero_q, zero_d;
  atm_pkg::angle_t                  ang_q, ang_d;

  // rounding and clamp of the accumulated angle
  always_comb begin
    zr = z_q + atm_pkg::ZW'(128);
    r  = RW'(zr >>> 8);
    if (zero_q) begin
      ang_d = '0;
    end else if (r > RW'(atm_pkg::AngleLimit)) begin
      ang_d = atm_pkg::AngleW'(atm_pkg::AngleLimit);
    end else if (r < -RW'(atm_pkg::AngleLimit)) begin
      ang_d = -atm_pkg::AngleW'(atm_pkg::AngleLimit);
    end else begin
      ang_d = atm_pkg::AngleW'(r);
    end
  end

  // micro-rotation
  always_comb begin
    dx     = y_q >>> cnt_q;
    dy     = x_q >>> cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    if (start_i) begin
      x_d    = atm_pkg::CordW'(den_i);
      y_d    = atm_pkg::CordW'(num_i) <<< 8;
      z_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      zero_d = (num_i == '0);
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atm_pkg::atan_q16(cnt_q);
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atm_pkg::atan_q16(cnt_q);
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == atm_pkg::StepW'(atm_pkg::Steps - 1)) begin
        busy_d = 1'b0;
      end
    end
    if (busy_q && !busy_d) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
    if (done_q) begin
      ang_q <= ang_d;
    end
  end

  // angle valid the cycle after done
  logic done_dly_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_dly_q <= 1'b0;
    end else begin
      done_dly_q <= done_q;
    end
  end

  assign done_o  = done_dly_q;
  assign angle_o = ang_q;

endmodule

>>> hw/rtl/atm_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module atm_div #(
  parameter int unsigned NumW = 21,
  parameter int unsigned DenW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_q, q_d;
  logic [DenW:0]   rem_q, rem_d, rem_sh;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;

  always_comb begin
    rem_sh = {rem_q[DenW-1:0], q_q[NumW-1]};
    q_d    = q_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      q_d    = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        q_d   = {q_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        q_d   = {q_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

>>> hw/rtl/accel_tilt_moving_mean.sv
`timescale 1ns / 1ps

// channel    dir  payload
// sample_i   in   accel_x, accel_y, accel_z (16 b signed)
// result_o   out  instant_pitch, instant_roll, mean_pitch, mean_roll (16 b signed)
//
// one sample at a time: capture, squares, sum, the bit-serial root, the cordic, the window
// update, the bit-serial mean divider and the output register, in that order.
// reset clears the window sum, fill count and ring pointer; history needs no clear.
// a result waits in the output register; the next sample is taken meanwhile, and
// the block stalls before writing its own result until that register is free.
module accel_tilt_moving_mean #(
  parameter int unsigned WINDOW = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  atm_in_if.sink    sample_i,
  atm_out_if.source result_o
);

  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam int unsigned PtrW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned TotW = atm_pkg::AngleW + $clog2(WINDOW) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_CORD = 3'd4;
  localparam logic [2:0] S_TOT  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;

  atm_pkg::axis_t ax_q, ay_q, az_q;
  logic [atm_pkg::SqW-1:0]  ax2_q, ay2_q, az2_q;
  logic [atm_pkg::SumW-1:0] sum_p, sum_r;

  logic                       root_go, root_p_done, root_r_done;
  logic [atm_pkg::RootW-1:0]  root_p, root_r;
  logic                       cord_go, cord_p_done, cord_r_done;
  atm_pkg::angle_t            ang_p, ang_r;
  logic signed [atm_pkg::AxisW:0] num_p, num_r;

  atm_pkg::angle_t   hist_p_mem [WINDOW];
  atm_pkg::angle_t   hist_r_mem [WINDOW];
  atm_pkg::angle_t   hist_p_q, hist_r_q;
  logic signed [TotW-1:0] tot_p_q, tot_r_q;
  logic [PtrW-1:0]   ptr_q;
  logic [CntW-1:0]   fill_q;

  logic              div_go_q, div_p_done, div_r_done;
  logic [TotW-1:0]   mag_p, mag_r, dnum_p, dnum_r, quot_p, quot_r;

  logic              out_valid_q;
  atm_pkg::angle_t   o_ip_q, o_ir_q, o_mp_q, o_mr_q;

  wire in_beat  = sample_i.valid && sample_i.ready;
  wire out_free = !out_valid_q || result_o.ready;

  // control sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (sample_i.valid) state_d = S_SQ;
      S_SQ:   state_d = S_SUM;
      S_SUM:  state_d = S_ROOT;
      S_ROOT: if (root_p_done) state_d = S_CORD;
      S_CORD: if (cord_p_done) state_d = S_TOT;
      S_TOT:  state_d = S_DIV;
      S_DIV:  if (div_p_done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign sample_i.ready = (state_q == S_IDLE);
  assign root_go = (state_q == S_SUM);
  assign cord_go = (state_q == S_ROOT) && root_p_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      div_go_q <= (state_q == S_TOT);
    end
  end

  // sample capture and squares
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      ax_q     <= sample_i.accel_x;
      ay_q     <= sample_i.accel_y;
      az_q     <= sample_i.accel_z;
      hist_p_q <= hist_p_mem[ptr_q];
      hist_r_q <= hist_r_mem[ptr_q];
    end
    if (state_q == S_SQ) begin
      ax2_q <= atm_pkg::SqW'(ax_q * ax_q);
      ay2_q <= atm_pkg::SqW'(ay_q * ay_q);
      az2_q <= atm_pkg::SqW'(az_q * az_q);
    end
  end

  assign sum_p = atm_pkg::SumW'(ax2_q) + atm_pkg::SumW'(az2_q);
  assign sum_r = atm_pkg::SumW'(ay2_q) + atm_pkg::SumW'(az2_q);
  assign num_p = (atm_pkg::AxisW + 1)'(ay_q);
  assign num_r = -(atm_pkg::AxisW + 1)'(ax_q);

  atm_isqrt u_root_p (
    .clk_i, .rst_ni, .start_i(root_go), .sum_i(sum_p), .done_o(root_p_done), .root_o(root_p)
  );
  atm_isqrt u_root_r (
    .clk_i, .rst_ni, .start_i(root_go), .sum_i(sum_r), .done_o(root_r_done), .root_o(root_r)
  );

  atm_cordic u_cord_p (
    .clk_i, .rst_ni, .start_i(cord_go), .den_i(root_p), .num_i(num_p),
    .done_o(cord_p_done), .angle_o(ang_p)
  );
  atm_cordic u_cord_r (
    .clk_i, .rst_ni, .start_i(cord_go), .den_i(root_r), .num_i(num_r),
    .done_o(cord_r_done), .angle_o(ang_r)
  );

  // history ring
  always_ff @(posedge clk_i) begin
    if (state_q == S_TOT) begin
      hist_p_mem[ptr_q] <= ang_p;
      hist_r_mem[ptr_q] <= ang_r;
    end
  end

  // running sums, pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_p_q <= '0;
      tot_r_q <= '0;
      ptr_q   <= '0;
      fill_q  <= '0;
    end else if (state_q == S_TOT) begin
      if (fill_q == CntW'(WINDOW)) begin
        tot_p_q <= tot_p_q - TotW'(hist_p_q) + TotW'(ang_p);
        tot_r_q <= tot_r_q - TotW'(hist_r_q) + TotW'(ang_r);
      end else begin
        tot_p_q <= tot_p_q + TotW'(ang_p);
        tot_r_q <= tot_r_q + TotW'(ang_r);
        fill_q  <= fill_q + 1'b1;
      end
      ptr_q <= (ptr_q == PtrW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

  // magnitude plus half the count, rounds half away from zero
  assign mag_p  = tot_p_q[TotW-1] ? TotW'(-tot_p_q) : TotW'(tot_p_q);
  assign mag_r  = tot_r_q[TotW-1] ? TotW'(-tot_r_q) : TotW'(tot_r_q);
  assign dnum_p = mag_p + TotW'(fill_q >> 1);
  assign dnum_r = mag_r + TotW'(fill_q >> 1);

  atm_div #(.NumW(TotW), .DenW(CntW)) u_div_p (
    .clk_i, .rst_ni, .start_i(div_go_q), .num_i(dnum_p), .den_i(fill_q),
    .done_o(div_p_done), .quot_o(quot_p)
  );
  atm_div #(.NumW(TotW), .DenW(CntW)) u_div_r (
    .clk_i, .rst_ni, .start_i(div_go_q), .num_i(dnum_r), .den_i(fill_q),
    .done_o(div_r_done), .quot_o(quot_r)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      o_ip_q <= ang_p;
      o_ir_q <= ang_r;
      o_mp_q <= tot_p_q[TotW-1] ? -atm_pkg::AngleW'(quot_p) : atm_pkg::AngleW'(quot_p);
      o_mr_q <= tot_r_q[TotW-1] ? -atm_pkg::AngleW'(quot_r) : atm_pkg::AngleW'(quot_r);
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.instant_pitch = o_ip_q;
  assign result_o.instant_roll  = o_ir_q;
  assign result_o.mean_pitch    = o_mp_q;
  assign result_o.mean_roll     = o_mr_q;

  // roll units run in lockstep with the pitch units
  logic unused_done;
  assign unused_done = root_r_done ^ cord_r_done ^ div_r_done;

endmodule

>>> hw/rtl/atm_checker.sv
`timescale 1ns / 1ps

// port-level checks
module atm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input atm_pkg::angle_t     instant_pitch_i,
  input atm_pkg::angle_t     mean_pitch_i,
  input atm_pkg::angle_t     mean_roll_i
);

  // result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before taken");

  // one sample in flight
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while busy");

  // angles in range: instant pitch and both means
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> instant_pitch_i <= 16'sd23040 && instant_pitch_i >= -16'sd23040)
    else $error("pitch out of range");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> mean_pitch_i <= 16'sd23040 && mean_pitch_i >= -16'sd23040 &&
                    mean_roll_i <= 16'sd23040 && mean_roll_i >= -16'sd23040)
    else $error("mean out of range");

endmodule

bind accel_tilt_moving_mean atm_checker u_atm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (sample_i.valid),
  .in_ready_i      (sample_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .instant_pitch_i (result_o.instant_pitch),
  .mean_pitch_i    (result_o.mean_pitch),
  .mean_roll_i     (result_o.mean_roll)
);

>>> tb/accel_tilt_moving_mean_tb.sv
`timescale 1ns / 1ps

module accel_tilt_moving_mean_tb;

  localparam int Window = 16;
  localparam int CordicSteps = 18;

  typedef struct packed {
    atm_pkg::angle_t instant_pitch;
    atm_pkg::angle_t instant_roll;
    atm_pkg::angle_t mean_pitch;
    atm_pkg::angle_t mean_roll;
  } tilt_t;

  typedef struct {
    atm_pkg::axis_t ax;
    atm_pkg::axis_t ay;
    atm_pkg::axis_t az;
    bit    known;
    tilt_t want;
  } vec_t;

  logic clk_i;
  logic rst_ni;

  atm_in_if  sample_if ();
  atm_out_if result_if ();

  accel_tilt_moving_mean #(.WINDOW(Window)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if.sink),
    .result_o(result_if.source)
  );

  // window state of the predictor
  atm_pkg::angle_t pitch_ring [Window];
  atm_pkg::angle_t roll_ring  [Window];
  longint     pitch_sum, roll_sum;
  int         slot, held;
  tilt_t      tilt_queue[$];
  int         mismatches;
  int         matched;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_root(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // atan2(n, sqrt(p^2+q^2)) in degrees * 256 by vectoring cordic
  function automatic longint tilt_deg(longint n, longint p, longint q);
    longint steps_q16 [CordicSteps] = '{2949120, 1740967, 919879, 466945, 234379,
      117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
    longint x, y, z, dx, dy, r;
    if (n == 0) return 0;
    x = int_root((p * p + q * q) <<< 16);
    y = n * 256;
    z = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += steps_q16[i];
      end else begin
        x -= dx; y += dy; z -= steps_q16[i];
      end
    end
    r = floor_shift(z + 128, 8);
    if (r > atm_pkg::AngleLimit) r = atm_pkg::AngleLimit;
    if (r < -atm_pkg::AngleLimit) r = -atm_pkg::AngleLimit;
    return r;
  endfunction

  function automatic longint round_mean(longint total, int cnt);
    longint mag, qt;
    mag = total < 0 ? -total : total;
    qt = (mag + cnt / 2) / cnt;
    return total < 0 ? -qt : qt;
  endfunction

  // advance the window by one sample, return the expected beat
  function automatic tilt_t predict_tilt(atm_pkg::axis_t ax, atm_pkg::axis_t ay,
                                         atm_pkg::axis_t az);
    tilt_t  t;
    longint pitch, roll;
    pitch = tilt_deg(ay, ax, az);
    roll  = tilt_deg(-longint'(ax), ay, az);
    if (held < Window) begin
      held++;
    end else begin
      pitch_sum -= pitch_ring[slot];
      roll_sum  -= roll_ring[slot];
    end
    pitch_ring[slot] = atm_pkg::angle_t'(pitch);
    roll_ring[slot]  = atm_pkg::angle_t'(roll);
    pitch_sum += pitch;
    roll_sum  += roll;
    slot = (slot + 1) % Window;
    t.instant_pitch = atm_pkg::angle_t'(pitch);
    t.instant_roll  = atm_pkg::angle_t'(roll);
    t.mean_pitch    = atm_pkg::angle_t'(round_mean(pitch_sum, held));
    t.mean_roll     = atm_pkg::angle_t'(round_mean(roll_sum, held));
    return t;
  endfunction

  function automatic vec_t mk(int x, int y, int z);
    vec_t v;
    v.ax = atm_pkg::axis_t'(x); v.ay = atm_pkg::axis_t'(y); v.az = atm_pkg::axis_t'(z);
    v.known = 1'b0;
    v.want = '0;
    return v;
  endfunction

  function automatic vec_t mk_known(int x, int y, int z, tilt_t w);
    vec_t v;
    v = mk(x, y, z);
    v.known = 1'b1;
    v.want = w;
    return v;
  endfunction

  task automatic send_sample(vec_t v);
    tilt_t t;
    int    gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid   <= 1'b1;
    sample_if.accel_x <= v.ax;
    sample_if.accel_y <= v.ay;
    sample_if.accel_z <= v.az;
    do @(posedge clk_i); while (!sample_if.ready);
    t = predict_tilt(v.ax, v.ay, v.az);
    if (v.known && t != v.want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row %0d/%0d/%0d: typed %h, predictor %h",
                 v.ax, v.ay, v.az, v.want, t);
    end
    tilt_queue.push_back(t);
  endtask

  // result side: random stalls, compare each beat with the oldest expectation
  initial begin
    tilt_t got, exp_t;
    int    gap;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
      got = {result_if.instant_pitch, result_if.instant_roll,
             result_if.mean_pitch, result_if.mean_roll};
      if (tilt_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        exp_t = tilt_queue.pop_front();
        if (got != exp_t) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected p=%0d r=%0d mp=%0d mr=%0d, got p=%0d r=%0d mp=%0d mr=%0d",
                     exp_t.instant_pitch, exp_t.instant_roll, exp_t.mean_pitch,
                     exp_t.mean_roll, got.instant_pitch, got.instant_roll,
                     got.mean_pitch, got.mean_roll);
        end else begin
          matched++;
        end
      end
    end
  end

  // stimulus
  initial begin
    vec_t table_rows[$];
    vec_t v;
    int   k, mode;
    mismatches = 0;
    matched = 0;
    pitch_sum = 0; roll_sum = 0; slot = 0; held = 0;
    sample_if.valid   = 1'b0;
    sample_if.accel_x = '0;
    sample_if.accel_y = '0;
    sample_if.accel_z = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: zero vector, axes, full scale, mixed corners
    table_rows.push_back(mk_known(0, 0, 0, '0));
    table_rows.push_back(mk_known(0, 0, 16384, '0));
    table_rows.push_back(mk(0, 16384, 0));
    table_rows.push_back(mk(0, -16384, 0));
    table_rows.push_back(mk(16384, 0, 0));
    table_rows.push_back(mk(-32768, 0, 0));
    table_rows.push_back(mk(32767, 0, 0));
    table_rows.push_back(mk(0, 32767, 0));
    table_rows.push_back(mk(0, -32768, 0));
    table_rows.push_back(mk(-32768, -32768, -32768));
    table_rows.push_back(mk(32767, 32767, 32767));
    table_rows.push_back(mk(-32768, 32767, 0));
    table_rows.push_back(mk(32767, -32768, -32768));
    table_rows.push_back(mk(1, 0, 0));
    table_rows.push_back(mk(0, -1, 0));
    table_rows.push_back(mk(-1, 1, 0));
    table_rows.push_back(mk(1, 1, 1));
    table_rows.push_back(mk(100, -200, 16000));
    table_rows.push_back(mk(-5000, 7000, -12000));
    table_rows.push_back(mk(0, 0, -32768));
    table_rows.push_back(mk(1, -1, -1));
    table_rows.push_back(mk(-32768, -32768, 0));
    foreach (table_rows[i]) send_sample(table_rows[i]);

    // random samples, half near 1 g with noise, the rest full range or small
    for (k = 0; k < 1250; k++) begin
      mode = $urandom_range(0, 9);
      if (mode < 5)
        v = mk($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
               $urandom_range(0, 2000) + 15000);
      else if (mode < 8)
        v = mk($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
               $urandom_range(0, 65535) - 32768);
      else
        v = mk($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
               $urandom_range(0, 6) - 3);
      send_sample(v);
      // stretches with no sender gaps happen whenever the draw gives zero
    end
    sample_if.valid <= 1'b0;

    while (tilt_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/atm_pkg.sv
hw/rtl/atm_if.sv
hw/rtl/atm_isqrt.sv
hw/rtl/atm_cordic.sv
hw/rtl/atm_div.sv
hw/rtl/accel_tilt_moving_mean.sv
hw/rtl/atm_checker.sv
tb/accel_tilt_moving_mean_tb.sv
